// ===== hw/rtl/arpr_pkg.sv =====
package arpr_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int PENDING_DEPTH = 16;

    localparam int CA_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CC_W = $clog2(CACHE_ENTRIES + 1);
    localparam int PA_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int PC_W = $clog2(PENDING_DEPTH + 1);

    localparam logic [1:0] CMD_SEND  = 2'd0;
    localparam logic [1:0] CMD_FRAME = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_REQ   = 2'd1;
    localparam logic [1:0] KIND_REPLY = 2'd2;
    localparam logic [1:0] KIND_DROP  = 2'd3;

    localparam logic [1:0] REG_OWN_IP   = 2'd0;
    localparam logic [1:0] REG_OWN_MAC  = 2'd1;
    localparam logic [1:0] REG_LIFETIME = 2'd2;

    localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
    localparam logic [15:0] ARP_OP_REQ    = 16'd1;
    localparam logic [15:0] ARP_OP_REPLY  = 16'd2;
    localparam logic [19:0] LIFETIME_RESET = 20'(30 * 1000);
    localparam logic [47:0] MAC_BCAST = {48{1'b1}};

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [19:0] life;
    } t_cword;

    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] handle;
    } t_pword;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CSCAN = 5'b00010,
        S_CINST = 5'b00100,
        S_PSCAN = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

endpackage

// ===== hw/rtl/arp_resolver_with_pending_queue.sv =====
// ARP resolver with a pending queue. One input word is taken at a time; o_ready is high
// only while the block is idle. The cache lives in a one-port-read, one-port-write RAM
// that is read one entry per cycle; a send, a tick and an ARP reply each walk it, and an
// ARP reply then walks the pending RAM the same way, though that walk holds while the
// output side stalls. An ARP request aimed at own_ip is answered without a cache walk.
// Results pass through an output register, so the first result may wait there while
// the walk goes on. Reset clears the cache valid bits and the pending count.
module arp_resolver_with_pending_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_next_hop_ip,
    input  logic [15:0] i_frame_handle,
    input  logic [15:0] i_frame_type,
    input  logic [15:0] i_arp_opcode,
    input  logic [31:0] i_arp_sender_ip,
    input  logic [47:0] i_arp_sender_mac,
    input  logic [31:0] i_arp_target_ip,
    input  logic [19:0] i_elapsed_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [47:0] o_dest_mac,
    output logic [31:0] o_target_ip,
    output logic [15:0] o_released_handle,
    output logic        o_last
);
    import arpr_pkg::*;

    t_state r_state, n_state;

    logic [31:0] r_own_ip;
    logic [47:0] r_own_mac;
    logic [19:0] r_lifetime;

    logic [1:0]  r_cmd, n_cmd;
    logic [31:0] r_hop, n_hop;
    logic [15:0] r_hnd, n_hnd;
    logic [31:0] r_sip, n_sip;
    logic [47:0] r_smac, n_smac;
    logic [19:0] r_el, n_el;

    logic [CACHE_ENTRIES-1:0] r_cval, n_cval;
    logic [CC_W-1:0] r_ci, n_ci;
    logic            r_cv, n_cv;
    logic [CA_W-1:0] r_cdi, n_cdi;
    logic            r_mfound, n_mfound;
    logic [CA_W-1:0] r_midx, n_midx;
    logic [CA_W-1:0] r_minidx, n_minidx;
    logic [19:0]     r_minlife, n_minlife;

    logic [PC_W-1:0] r_pcnt, n_pcnt;
    logic [PC_W-1:0] r_pr, n_pr;
    logic [PC_W-1:0] r_pw, n_pw;
    logic            r_pv, n_pv;

    logic        r_hv, n_hv;
    logic [1:0]  r_hkind, n_hkind;
    logic [47:0] r_hmac, n_hmac;
    logic [31:0] r_hip, n_hip;
    logic [15:0] r_hhnd, n_hhnd;

    logic        r_ov, n_ov;
    logic [1:0]  r_okind, n_okind;
    logic [47:0] r_omac, n_omac;
    logic [31:0] r_oip, n_oip;
    logic [15:0] r_ohnd, n_ohnd;
    logic        r_olast, n_olast;

    logic            c_we, c_re;
    logic [CA_W-1:0] c_waddr, c_raddr;
    t_cword          c_wdata, c_rdata;
    logic            p_we, p_re;
    logic [PA_W-1:0] p_waddr, p_raddr;
    t_pword          p_wdata, p_rdata;

    logic            out_free;
    logic            free_found;
    logic [CA_W-1:0] free_idx;
    logic [CA_W-1:0] slot;
    logic            ent_vld;
    logic            last_idx;
    logic [19:0]     new_life;
    logic            pmatch;
    logic            pstall;

    arpr_ram #(.WIDTH($bits(t_cword)), .DEPTH(CACHE_ENTRIES), .AW(CA_W)) u_cache (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (c_re),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    arpr_ram #(.WIDTH($bits(t_pword)), .DEPTH(PENDING_DEPTH), .AW(PA_W)) u_pend (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_re    (p_re),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign out_free = !r_ov || i_ready;

    // lowest free cache slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
            if (!r_cval[i]) begin
                free_found = 1'b1;
                free_idx   = CA_W'(i);
            end
        end
    end

    always_comb begin
        ent_vld  = r_cval[r_cdi];
        last_idx = (r_cdi == CA_W'(CACHE_ENTRIES - 1));
        new_life = (c_rdata.life > r_el) ? (c_rdata.life - r_el) : 20'd0;
        pmatch   = r_pv && (p_rdata.ip == r_sip);
        pstall   = pmatch && r_hv && !out_free;
        if (r_mfound) begin
            slot = r_midx;
        end else if (free_found) begin
            slot = free_idx;
        end else begin
            slot = r_minidx;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_hop     = r_hop;
        n_hnd     = r_hnd;
        n_sip     = r_sip;
        n_smac    = r_smac;
        n_el      = r_el;
        n_cval    = r_cval;
        n_ci      = r_ci;
        n_cv      = r_cv;
        n_cdi     = r_cdi;
        n_mfound  = r_mfound;
        n_midx    = r_midx;
        n_minidx  = r_minidx;
        n_minlife = r_minlife;
        n_pcnt    = r_pcnt;
        n_pr      = r_pr;
        n_pw      = r_pw;
        n_pv      = r_pv;
        n_hv      = r_hv;
        n_hkind   = r_hkind;
        n_hmac    = r_hmac;
        n_hip     = r_hip;
        n_hhnd    = r_hhnd;
        n_okind   = r_okind;
        n_omac    = r_omac;
        n_oip     = r_oip;
        n_ohnd    = r_ohnd;
        n_olast   = r_olast;
        n_ov      = i_ready ? 1'b0 : r_ov;
        c_we      = 1'b0;
        c_waddr   = r_cdi;
        c_wdata   = '0;
        c_re      = 1'b0;
        c_raddr   = r_ci[CA_W-1:0];
        p_we      = 1'b0;
        p_waddr   = r_pw[PA_W-1:0];
        p_wdata   = '0;
        p_re      = 1'b0;
        p_raddr   = r_pr[PA_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd    = i_command;
                    n_hop    = i_next_hop_ip;
                    n_hnd    = i_frame_handle;
                    n_sip    = i_arp_sender_ip;
                    n_smac   = i_arp_sender_mac;
                    n_el     = i_elapsed_ms;
                    n_ci     = '0;
                    n_cv     = 1'b0;
                    n_mfound = 1'b0;
                    priority case (i_command)
                        CMD_SEND, CMD_TICK: n_state = S_CSCAN;
                        CMD_FRAME: begin
                            if (i_frame_type == ETHERTYPE_ARP) begin
                                if (i_arp_opcode == ARP_OP_REQ) begin
                                    if (i_arp_target_ip == r_own_ip) begin
                                        n_hv    = 1'b1;
                                        n_hkind = KIND_REPLY;
                                        n_hmac  = i_arp_sender_mac;
                                        n_hip   = i_arp_sender_ip;
                                        n_hhnd  = '0;
                                        n_state = S_FLUSH;
                                    end
                                end else if (i_arp_opcode == ARP_OP_REPLY) begin
                                    n_state = S_CSCAN;
                                end
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            S_CSCAN: begin
                // one read issued per cycle, data of the previous one checked
                if (r_ci < CC_W'(CACHE_ENTRIES)) begin
                    c_re  = 1'b1;
                    n_ci  = r_ci + CC_W'(1);
                    n_cv  = 1'b1;
                    n_cdi = r_ci[CA_W-1:0];
                end else begin
                    n_cv = 1'b0;
                end
                if (r_cv) begin
                    priority case (r_cmd)
                        CMD_SEND: begin
                            if (ent_vld && c_rdata.ip == r_hop) begin
                                n_hv    = 1'b1;
                                n_hkind = KIND_DATA;
                                n_hmac  = c_rdata.mac;
                                n_hip   = '0;
                                n_hhnd  = r_hnd;
                                n_state = S_FLUSH;
                            end else if (last_idx) begin
                                n_hv    = 1'b1;
                                n_state = S_FLUSH;
                                if (r_pcnt < PC_W'(PENDING_DEPTH)) begin
                                    p_we    = 1'b1;
                                    p_waddr = r_pcnt[PA_W-1:0];
                                    p_wdata = '{ip: r_hop, handle: r_hnd};
                                    n_pcnt  = r_pcnt + PC_W'(1);
                                    n_hkind = KIND_REQ;
                                    n_hmac  = MAC_BCAST;
                                    n_hip   = r_hop;
                                    n_hhnd  = '0;
                                end else begin
                                    n_hkind = KIND_DROP;
                                    n_hmac  = '0;
                                    n_hip   = '0;
                                    n_hhnd  = r_hnd;
                                end
                            end
                        end
                        CMD_FRAME: begin
                            if (ent_vld && c_rdata.ip == r_sip && !r_mfound) begin
                                n_mfound = 1'b1;
                                n_midx   = r_cdi;
                            end
                            if (r_cdi == '0 || c_rdata.life < r_minlife) begin
                                n_minidx  = r_cdi;
                                n_minlife = c_rdata.life;
                            end
                            if (last_idx) begin
                                n_state = S_CINST;
                            end
                        end
                        default: begin
                            if (ent_vld) begin
                                c_we    = 1'b1;
                                c_waddr = r_cdi;
                                c_wdata = '{ip: c_rdata.ip, mac: c_rdata.mac, life: new_life};
                                if (new_life == '0) begin
                                    n_cval[r_cdi] = 1'b0;
                                end
                            end
                            if (last_idx) begin
                                n_state = S_IDLE;
                            end
                        end
                    endcase
                end
            end

            S_CINST: begin
                c_we         = 1'b1;
                c_waddr      = slot;
                c_wdata      = '{ip: r_sip, mac: r_smac, life: r_lifetime};
                n_cval[slot] = 1'b1;
                n_pr         = '0;
                n_pw         = '0;
                n_pv         = 1'b0;
                n_hv         = 1'b0;
                n_state      = S_PSCAN;
            end

            S_PSCAN: begin
                // matched words leave through the hold register so the final
                // one can be marked last; others are packed down to r_pw
                if (!pstall) begin
                    if (r_pv) begin
                        if (pmatch) begin
                            if (r_hv) begin
                                n_ov    = 1'b1;
                                n_okind = r_hkind;
                                n_omac  = r_hmac;
                                n_oip   = r_hip;
                                n_ohnd  = r_hhnd;
                                n_olast = 1'b0;
                            end
                            n_hv    = 1'b1;
                            n_hkind = KIND_DATA;
                            n_hmac  = r_smac;
                            n_hip   = '0;
                            n_hhnd  = p_rdata.handle;
                        end else begin
                            p_we    = 1'b1;
                            p_waddr = r_pw[PA_W-1:0];
                            p_wdata = p_rdata;
                            n_pw    = r_pw + PC_W'(1);
                        end
                    end
                    if (r_pr < r_pcnt) begin
                        p_re = 1'b1;
                        n_pr = r_pr + PC_W'(1);
                        n_pv = 1'b1;
                    end else begin
                        n_pv = 1'b0;
                    end
                    if (!r_pv && r_pr == r_pcnt) begin
                        n_pcnt  = r_pw;
                        n_state = S_FLUSH;
                    end
                end
            end

            S_FLUSH: begin
                if (!r_hv) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_ov    = 1'b1;
                    n_okind = r_hkind;
                    n_omac  = r_hmac;
                    n_oip   = r_hip;
                    n_ohnd  = r_hhnd;
                    n_olast = 1'b1;
                    n_hv    = 1'b0;
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_own_ip   <= '0;
            r_own_mac  <= '0;
            r_lifetime <= LIFETIME_RESET;
            r_cval     <= '0;
            r_ci       <= '0;
            r_cv       <= 1'b0;
            r_mfound   <= 1'b0;
            r_pcnt     <= '0;
            r_pr       <= '0;
            r_pw       <= '0;
            r_pv       <= 1'b0;
            r_hv       <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cval   <= n_cval;
            r_ci     <= n_ci;
            r_cv     <= n_cv;
            r_mfound <= n_mfound;
            r_pcnt   <= n_pcnt;
            r_pr     <= n_pr;
            r_pw     <= n_pw;
            r_pv     <= n_pv;
            r_hv     <= n_hv;
            r_ov     <= n_ov;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_OWN_IP:   r_own_ip   <= i_cfg_data[31:0];
                    REG_OWN_MAC:  r_own_mac  <= i_cfg_data;
                    REG_LIFETIME: r_lifetime <= i_cfg_data[19:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_hop     <= n_hop;
        r_hnd     <= n_hnd;
        r_sip     <= n_sip;
        r_smac    <= n_smac;
        r_el      <= n_el;
        r_cdi     <= n_cdi;
        r_midx    <= n_midx;
        r_minidx  <= n_minidx;
        r_minlife <= n_minlife;
        r_hkind   <= n_hkind;
        r_hmac    <= n_hmac;
        r_hip     <= n_hip;
        r_hhnd    <= n_hhnd;
        r_okind   <= n_okind;
        r_omac    <= n_omac;
        r_oip     <= n_oip;
        r_ohnd    <= n_ohnd;
        r_olast   <= n_olast;
    end

    // own_mac is kept for the sender field of outgoing frames, built downstream
    logic unused_own_mac;
    assign unused_own_mac = ^r_own_mac;

    assign o_valid           = r_ov & (r_ov | unused_own_mac);
    assign o_kind            = r_okind;
    assign o_dest_mac        = r_omac;
    assign o_target_ip       = r_oip;
    assign o_released_handle = r_ohnd;
    assign o_last            = r_olast;

endmodule

// ===== hw/rtl/arpr_ram.sv =====
module arpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
